### rtl/m2x_pkg.sv
// ============================================================================
// m2x_pkg
// Shared types, operation codes and helpers for the 2x2 matrix unit.
// ============================================================================
package m2x_pkg;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MATMUL = 4'd2;
    localparam logic [3:0] OP_SMUL   = 4'd3;
    localparam logic [3:0] OP_SDIV   = 4'd4;
    localparam logic [3:0] OP_MATVEC = 4'd5;
    localparam logic [3:0] OP_TRANS  = 4'd6;
    localparam logic [3:0] OP_DET    = 4'd7;
    localparam logic [3:0] OP_INV    = 4'd8;
    localparam logic [3:0] OP_AINVB  = 4'd9;

    localparam int LANES    = 4;
    localparam int QBITS    = 32;
    localparam int MUL_LAT  = 3;
    localparam int DIV_LAT  = QBITS + 2;
    localparam int DET_LAT  = MUL_LAT;
    localparam int MUL_AT   = DET_LAT + DIV_LAT;
    localparam int LAST     = MUL_AT + MUL_LAT;
    localparam int DET_HOLD = LAST - DET_LAT;

    localparam logic signed [48:0] Q_MAX = 49'sd2147483647;
    localparam logic signed [48:0] Q_MIN = -49'sd2147483648;

    typedef struct packed {
        logic [3:0]        op;
        logic [3:0][31:0]  a;
        logic [3:0][31:0]  b;
        logic [31:0]       s;
    } item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_res_t;

    typedef struct packed {
        logic        zero;
        logic [31:0] val;
        logic        sat;
    } det_info_t;

    typedef struct packed {
        logic [3:0][31:0] val;
        logic [3:0]       sat;
    } div_res_t;

    typedef struct packed {
        logic [31:0]      sc;
        logic [3:0][31:0] r;
        logic             dz;
        logic             sat;
    } res_t;

    function automatic sat_res_t sat32(input logic signed [48:0] v);
        sat_res_t r;
        r.val = v[31:0];
        r.sat = 1'b0;
        if (v > Q_MAX)
        begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end
        else if (v < Q_MIN)
        begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? 32'(~x + 32'd1) : x;
    endfunction

endpackage

### rtl/m2x_mul_lane.sv
// ============================================================================
// m2x_mul_lane
// Two rounded Q16.16 products summed at full width: x0*y0 +/- x1*y1.
// ============================================================================
module m2x_mul_lane
    import m2x_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  x0,
    input  logic signed [31:0]  y0,
    input  logic signed [31:0]  x1,
    input  logic signed [31:0]  y1,
    input  logic                neg1,
    output logic signed [48:0]  sum
);

    logic [31:0]        mx0_reg, my0_reg, mx1_reg, my1_reg;
    logic               s0_reg, s1_reg, s0_d_reg, s1_d_reg;
    logic [63:0]        p0_reg, p1_reg;
    logic signed [48:0] sum_reg;
    logic [63:0]        rnd0, rnd1;
    logic signed [48:0] t0, t1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx0_reg  <= mag32(x0);
            my0_reg  <= mag32(y0);
            mx1_reg  <= mag32(x1);
            my1_reg  <= mag32(y1);
            s0_reg   <= x0[31] ^ y0[31];
            s1_reg   <= x1[31] ^ y1[31] ^ neg1;
            p0_reg   <= mx0_reg * my0_reg;
            p1_reg   <= mx1_reg * my1_reg;
            s0_d_reg <= s0_reg;
            s1_d_reg <= s1_reg;
            sum_reg  <= t0 + t1;
        end
    end

    always_comb
    begin
        rnd0 = p0_reg + 64'd32768;
        rnd1 = p1_reg + 64'd32768;
        t0   = s0_d_reg ? -$signed({1'b0, rnd0[63:16]}) : $signed({1'b0, rnd0[63:16]});
        t1   = s1_d_reg ? -$signed({1'b0, rnd1[63:16]}) : $signed({1'b0, rnd1[63:16]});
    end

    assign sum = sum_reg;

endmodule

### rtl/m2x_div_lane.sv
// ============================================================================
// m2x_div_lane
// Pipelined rounded Q16.16 divide, one quotient bit per stage, saturating.
// ============================================================================
module m2x_div_lane
    import m2x_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [32:0]  n,
    input  logic signed [48:0]  d,
    output logic [31:0]         t,
    output logic                sat
);

    logic [48:0]      rem_reg [0:QBITS-1];
    logic [48:0]      den_reg [0:QBITS-1];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic             ovf_reg [0:QBITS];
    logic             neg_reg [0:QBITS];
    logic [31:0]      t_reg;
    logic             sat_reg;

    logic [32:0] magn;
    logic [48:0] magd;
    logic [48:0] num2;
    logic [48:0] nn;
    logic [48:0] dd;

    always_comb
    begin
        magn = n[32] ? -n : n;
        magd = d[48] ? -d : d;
        num2 = {magn[31:0], 17'd0};
        nn   = num2 + magd;
        dd   = {magd[47:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= nn;
            den_reg[0] <= dd;
            q_reg[0]   <= '0;
            ovf_reg[0] <= 49'(nn[48:32]) >= dd;
            neg_reg[0] <= n[32] ^ d[48];
        end
    end

    for (genvar j = 0; j < QBITS; j++)
    begin : g_stage
        localparam int K = QBITS - 1 - j;
        logic ge;
        assign ge = (rem_reg[j] >> K) >= den_reg[j];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]   <= {q_reg[j][QBITS-2:0], ge};
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end

        if (j < QBITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? rem_reg[j] - (den_reg[j] << K) : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    logic [31:0] qf;
    logic        big;
    assign qf  = q_reg[QBITS];
    assign big = neg_reg[QBITS] ? (qf[31] && (qf[30:0] != '0)) : qf[31];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= ovf_reg[QBITS] || big;
            if (ovf_reg[QBITS] || big)
                t_reg <= neg_reg[QBITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                t_reg <= neg_reg[QBITS] ? 32'(~qf + 32'd1) : qf;
        end
    end

    assign t   = t_reg;
    assign sat = sat_reg;

endmodule

### rtl/matrix2x2_arithmetic_unit.sv
// ============================================================================
// matrix2x2_arithmetic_unit
// 2x2 Q16.16 matrix unit: a determinant lane, four divide lanes, four multiply lanes, merge.
// ============================================================================
// Usage:
//   Input beats arrive on s_tvalid/s_tready with matrices A, B and the
//   scalar in s_tdata and the operation code in s_tuser. Each beat gives one
//   result beat on m_tvalid/m_tready: the 2x2 result and scalar_out in
//   m_tdata, the saturated and divide_by_zero flags in m_tuser.
//   Every operation passes through the same stages from the accepting edge
//   to m_tvalid: determinant lane, divider (one quotient bit per stage, 32
//   stages plus setup and rounding), multiply lanes, output register.
//   Throughput is one beat per cycle while s_tready is high; the pipeline
//   holds up to 41 beats, plus one in the output register and one in the
//   skid register.
//   Results leave through an output register backed by a one-entry skid
//   register, so s_tready does not depend on m_tready in the same cycle.
//   When the receiver stalls and another result arrives, the skid fills and
//   the whole pipeline freezes in the next cycle with s_tready low; nothing is dropped.
//   Reset clears all valid flags; the pipeline data is left as is.
// ============================================================================
module matrix2x2_arithmetic_unit
    import m2x_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // a_r0c0, a_r0c1, a_r1c0, a_r1c1, b_r0c0..b_r1c1, scalar_in
    input  logic [3:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // r_r0c0, r_r0c1, r_r1c0, r_r1c1, scalar_out
    output logic [1:0]   m_tuser    // saturated, divide_by_zero
);

    logic        en;
    item_t       in_item;
    item_t       sb_reg [0:LAST];
    logic [LAST:0] vld_reg;
    logic        out_valid_reg, skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign in_item.op = s_tuser;
    assign in_item.a  = s_tdata[127:0];
    assign in_item.b  = s_tdata[255:128];
    assign in_item.s  = s_tdata[287:256];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= in_item;
            for (int k = 1; k <= LAST; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // determinant of A, or of B for A*inv(B)
    item_t              di;
    logic [3:0][31:0]   dm;
    logic signed [48:0] det_sum;

    assign di = sb_reg[0];
    assign dm = (di.op == OP_AINVB) ? di.b : di.a;

    m2x_mul_lane u_det (
        .clk  (clk),
        .en   (en),
        .x0   (dm[0]),
        .y0   (dm[3]),
        .x1   (dm[1]),
        .y1   (dm[2]),
        .neg1 (1'b1),
        .sum  (det_sum)
    );

    det_info_t det_info;
    sat_res_t  det_sr;
    det_info_t dp_reg [1:DET_HOLD];

    always_comb
    begin
        det_sr        = sat32(det_sum);
        det_info.zero = (det_sum == '0);
        det_info.val  = det_sr.val;
        det_info.sat  = det_sr.sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_reg[1] <= det_info;
            for (int k = 2; k <= DET_HOLD; k++)
                dp_reg[k] <= dp_reg[k-1];
        end
    end

    // divide lanes
    item_t              vi;
    logic [3:0][31:0]   vm;
    logic signed [32:0] div_n [0:LANES-1];
    logic signed [48:0] div_d [0:LANES-1];
    div_res_t           dv;
    div_res_t           tp_reg [1:MUL_LAT];

    assign vi = sb_reg[DET_LAT];
    assign vm = (vi.op == OP_AINVB) ? vi.b : vi.a;

    always_comb
    begin
        if (vi.op == OP_SDIV)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                div_n[i] = 33'($signed(vi.a[i]));
                div_d[i] = 49'($signed(vi.s));
            end
        end
        else
        begin
            div_n[0] = 33'($signed(vm[3]));
            div_n[1] = 33'sd0 - 33'($signed(vm[1]));
            div_n[2] = 33'sd0 - 33'($signed(vm[2]));
            div_n[3] = 33'($signed(vm[0]));
            for (int i = 0; i < LANES; i++)
                div_d[i] = det_sum;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        m2x_div_lane u_div (
            .clk (clk),
            .en  (en),
            .n   (div_n[i]),
            .d   (div_d[i]),
            .t   (dv.val[i]),
            .sat (dv.sat[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tp_reg[1] <= dv;
            for (int k = 2; k <= MUL_LAT; k++)
                tp_reg[k] <= tp_reg[k-1];
        end
    end

    // multiply lanes, one per result element
    item_t              mi;
    logic [3:0][31:0]   mb;
    logic [31:0]        mx0 [0:LANES-1];
    logic [31:0]        my0 [0:LANES-1];
    logic [31:0]        mx1 [0:LANES-1];
    logic [31:0]        my1 [0:LANES-1];
    logic signed [48:0] ln_sum [0:LANES-1];

    assign mi = sb_reg[MUL_AT];
    assign mb = (mi.op == OP_AINVB) ? dv.val : mi.b;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (mi.op == OP_SMUL)
            begin
                mx0[i] = mi.a[i];
                my0[i] = mi.s;
                mx1[i] = '0;
                my1[i] = '0;
            end
            else
            begin
                mx0[i] = mi.a[(i / 2) * 2];
                my0[i] = mb[i % 2];
                mx1[i] = mi.a[(i / 2) * 2 + 1];
                my1[i] = mb[2 + (i % 2)];
            end
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_mul
        m2x_mul_lane u_mul (
            .clk  (clk),
            .en   (en),
            .x0   (mx0[i]),
            .y0   (my0[i]),
            .x1   (mx1[i]),
            .y1   (my1[i]),
            .neg1 (1'b0),
            .sum  (ln_sum[i])
        );
    end

    // merge
    item_t              li;
    det_info_t          ld;
    div_res_t           lt;
    sat_res_t           lsr [0:LANES-1];
    sat_res_t           asr [0:LANES-1];
    logic signed [48:0] addsub [0:LANES-1];
    logic [LANES-1:0]   lsat;
    res_t               res;

    assign li = sb_reg[LAST];
    assign ld = dp_reg[DET_HOLD];
    assign lt = tp_reg[MUL_LAT];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lsr[i]    = sat32(ln_sum[i]);
            lsat[i]   = lsr[i].sat;
            addsub[i] = (li.op == OP_SUB) ?
                        49'($signed(li.a[i])) - 49'($signed(li.b[i])) :
                        49'($signed(li.a[i])) + 49'($signed(li.b[i]));
            asr[i]    = sat32(addsub[i]);
        end

        res = '0;
        unique case (li.op)
            OP_ADD, OP_SUB:
            begin
                for (int i = 0; i < LANES; i++)
                    res.r[i] = asr[i].val;
                res.sat = asr[0].sat | asr[1].sat | asr[2].sat | asr[3].sat;
            end
            OP_MATMUL, OP_SMUL:
            begin
                for (int i = 0; i < LANES; i++)
                    res.r[i] = lsr[i].val;
                res.sat = |lsat;
            end
            OP_SDIV:
            begin
                if (li.s == '0)
                    res.dz = 1'b1;
                else
                begin
                    res.r   = lt.val;
                    res.sat = |lt.sat;
                end
            end
            OP_MATVEC:
            begin
                res.r[0] = lsr[0].val;
                res.r[2] = lsr[2].val;
                res.sat  = lsat[0] | lsat[2];
            end
            OP_TRANS:
            begin
                res.r[0] = li.a[0];
                res.r[1] = li.a[2];
                res.r[2] = li.a[1];
                res.r[3] = li.a[3];
            end
            OP_DET:
            begin
                res.sc  = ld.val;
                res.sat = ld.sat;
            end
            OP_INV:
            begin
                if (ld.zero)
                    res.dz = 1'b1;
                else
                begin
                    res.r   = lt.val;
                    res.sat = |lt.sat;
                end
            end
            OP_AINVB:
            begin
                if (ld.zero)
                    res.dz = 1'b1;
                else
                begin
                    for (int i = 0; i < LANES; i++)
                        res.r[i] = lsr[i].val;
                    res.sat = (|lt.sat) | (|lsat);
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // output register with skid
    res_t out_reg, skid_reg;
    logic incoming;

    assign incoming = en && vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= incoming;
        end
        else if (incoming)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (incoming)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.sc, out_reg.r};
    assign m_tuser  = {out_reg.dz, out_reg.sat};

endmodule

### rtl/m2x_checker.sv
// ============================================================================
// m2x_checker
// Port-level checks for the 2x2 matrix unit, bound to the top level.
// ============================================================================
module m2x_checker
    import m2x_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic [1:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
        else $error("divide by zero beat not cleared");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[159:128] != '0 |-> m_tdata[127:0] == '0)
        else $error("scalar and matrix results both nonzero");

endmodule

bind matrix2x2_arithmetic_unit m2x_checker u_m2x_checker (.*);

### sim/tb_matrix2x2_arithmetic_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_matrix2x2_arithmetic_unit
// Stream testbench for the 2x2 Q16.16 matrix unit. A directed table covers
// extremes, every operation, singular inputs and undefined codes. Random
// beats follow. Every result beat is checked in order against the table's fixed
// expected value or a predictor of the rounding, saturation and divide-by-zero rules.
// ============================================================================
module tb_matrix2x2_arithmetic_unit;
    import m2x_pkg::*;

    localparam int N_RANDOM   = 1530;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [3:0] OP_UNDEF_LO = 4'd10;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;
    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] QONE = 32'h0001_0000;

    typedef struct packed {
        logic [3:0][31:0] r;
        logic [31:0]      sc;
        logic             sat;
        logic             dz;
    } mres_t;

    typedef struct {
        logic [3:0]       op;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [31:0]      s;
        bit               fixed;
        mres_t            exp;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;    // a_r0c0, a_r0c1, a_r1c0, a_r1c1, b_r0c0..b_r1c1, scalar_in
    logic [3:0]   s_tuser;    // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;    // r_r0c0, r_r0c1, r_r1c0, r_r1c1, scalar_out
    logic [1:0]   m_tuser;    // saturated, divide_by_zero

    mres_t pending_results[$];
    row_t  rows[$];
    int    fails;
    int    n_checked;
    int    n_sent;
    int    idle_cycles;
    int    op_seen[16];

    matrix2x2_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned magn(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint clamp(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint x, input longint y);
        longint unsigned m;
        m = (magn(x) * magn(y) + 64'd32768) >> 16;
        return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint qdiv(input longint n, input longint d);
        longint unsigned num, den, q;
        num = magn(n) << 16;
        den = magn(d);
        q = (2 * num + den) / (2 * den);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void mat_product(input longint x[4], input longint y[4],
                                        output longint r[4], inout bit sat);
        r[0] = clamp(qmul(x[0], y[0]) + qmul(x[1], y[2]), sat);
        r[1] = clamp(qmul(x[0], y[1]) + qmul(x[1], y[3]), sat);
        r[2] = clamp(qmul(x[2], y[0]) + qmul(x[3], y[2]), sat);
        r[3] = clamp(qmul(x[2], y[1]) + qmul(x[3], y[3]), sat);
    endfunction

    function automatic longint det_of(input longint m[4]);
        return qmul(m[0], m[3]) - qmul(m[1], m[2]);
    endfunction

    function automatic bit mat_inverse(input longint m[4], output longint r[4], inout bit sat);
        longint d;
        d = det_of(m);
        r = '{default: 0};
        if (d == 0)
            return 1'b0;
        r[0] = clamp(qdiv(m[3], d), sat);
        r[1] = clamp(qdiv(-m[1], d), sat);
        r[2] = clamp(qdiv(-m[2], d), sat);
        r[3] = clamp(qdiv(m[0], d), sat);
        return 1'b1;
    endfunction

    function automatic mres_t predict_matrix_op(input logic [3:0] op, input logic [3:0][31:0] av,
                                                input logic [3:0][31:0] bv, input logic [31:0] sv);
        longint a[4], b[4], r[4], t[4], s, sc;
        bit sat, dz;
        mres_t res;
        sat = 1'b0;
        dz = 1'b0;
        sc = 0;
        r = '{default: 0};
        for (int i = 0; i < 4; i++)
        begin
            a[i] = sx(av[i]);
            b[i] = sx(bv[i]);
        end
        s = sx(sv);
        case (op)
            OP_ADD:    for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i], sat);
            OP_SUB:    for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i], sat);
            OP_MATMUL: mat_product(a, b, r, sat);
            OP_SMUL:   for (int i = 0; i < 4; i++) r[i] = clamp(qmul(a[i], s), sat);
            OP_SDIV:
            begin
                if (s == 0)
                    dz = 1'b1;
                else
                    for (int i = 0; i < 4; i++) r[i] = clamp(qdiv(a[i], s), sat);
            end
            OP_MATVEC:
            begin
                r[0] = clamp(qmul(a[0], b[0]) + qmul(a[1], b[2]), sat);
                r[2] = clamp(qmul(a[2], b[0]) + qmul(a[3], b[2]), sat);
            end
            OP_TRANS:
            begin
                r[0] = a[0];
                r[1] = a[2];
                r[2] = a[1];
                r[3] = a[3];
            end
            OP_DET:    sc = clamp(det_of(a), sat);
            OP_INV:
            begin
                if (!mat_inverse(a, r, sat))
                begin
                    dz = 1'b1;
                    r = '{default: 0};
                end
            end
            OP_AINVB:
            begin
                if (!mat_inverse(b, t, sat))
                begin
                    dz = 1'b1;
                    sat = 1'b0;
                end
                else
                    mat_product(a, t, r, sat);
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) res.r[i] = r[i][31:0];
        res.sc = sc[31:0];
        res.sat = sat;
        res.dz = dz;
        return res;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3, 4:    return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            5:       return 32'($signed($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000);
            6:       return $urandom_range(0, 1) ? QMAX : QMIN;
            7:       return $urandom_range(0, 1) ? QONE : -QONE;
            8:       return 32'($urandom_range(0, 3)) - 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 15);
        if (k < 9)
            return 0;
        if (k < 14)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic add_row(input logic [3:0] op, input logic [31:0] a0, a1, a2, a3,
                           input logic [31:0] b0, b1, b2, b3, input logic [31:0] s,
                           input bit fixed, input mres_t exp);
        row_t rw;
        rw.op = op;
        rw.a = {a3, a2, a1, a0};
        rw.b = {b3, b2, b1, b0};
        rw.s = s;
        rw.fixed = fixed;
        rw.exp = exp;
        rows.push_back(rw);
    endtask

    task automatic send_beat(input logic [3:0] op, input logic [3:0][31:0] a,
                             input logic [3:0][31:0] b, input logic [31:0] s,
                             input bit fixed, input mres_t exp);
        bit acc;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {s, b, a};
        do
        begin
            @(negedge clk);
            acc = s_tready;
            @(posedge clk);
        end
        while (!acc);
        pending_results.push_back(fixed ? exp : predict_matrix_op(op, a, b, s));
        op_seen[op]++;
        n_sent++;
        begin
            int g;
            g = gap_len();
            if (g > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= {9{$urandom()}};
                repeat (g) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        mres_t zr, sat_hi, sat_lo, dz_only;
        logic [3:0][31:0] a, b;
        logic [31:0] s;
        logic [3:0] op;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        fails = 0;
        n_checked = 0;
        n_sent = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        zr = '0;
        sat_hi = '0;
        sat_hi.r = {4{QMAX}};
        sat_hi.sat = 1'b1;
        sat_lo = '0;
        sat_lo.r = {4{QMIN}};
        sat_lo.sat = 1'b1;
        dz_only = '0;
        dz_only.dz = 1'b1;

        add_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, zr);
        add_row(OP_ADD, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0, 1, sat_hi);
        add_row(OP_ADD, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMAX, 1, sat_lo);
        add_row(OP_SUB, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX, 0, 1, sat_lo);
        add_row(OP_SUB, QMAX, QMIN, 5, -7, 3, 9, QMIN, QMAX, 0, 0, zr);
        add_row(OP_MATMUL, QONE, 0, 0, QONE, 123, -456, 789, QMIN, 0, 0, zr);
        add_row(OP_MATMUL, QMAX, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, QMIN, 0, 0, zr);
        add_row(OP_MATMUL, 1, 1, -1, 1, 32'h8000, 32'h8000, 32'h7FFF, 32'h8001, 0, 0, zr);
        add_row(OP_SMUL, QMAX, QMIN, 1, -1, 0, 0, 0, 0, QMIN, 0, zr);
        add_row(OP_SMUL, 32'h1234_5678, 3, -3, QONE, 0, 0, 0, 0, 32'h8000, 0, zr);
        add_row(OP_SDIV, QMAX, 1, 2, 3, 0, 0, 0, 0, 0, 1, dz_only);
        add_row(OP_SDIV, QMAX, QMIN, 1, -1, 0, 0, 0, 0, 1, 0, zr);
        add_row(OP_SDIV, QMIN, 3, -5, QONE, 0, 0, 0, 0, QMIN, 0, zr);
        add_row(OP_MATVEC, QONE, 2*QONE, -QONE, QMAX, 3*QONE, QMAX, QMIN, QMIN, 0, 0, zr);
        add_row(OP_TRANS, QMAX, QMIN, 32'h1111, 32'h2222, 0, 0, 0, 0, 0, 0, zr);
        add_row(OP_DET, QMAX, QMIN, QMAX, QMAX, 0, 0, 0, 0, 0, 0, zr);
        add_row(OP_DET, 2*QONE, QONE, QONE, 3*QONE, 0, 0, 0, 0, 0, 0, zr);
        add_row(OP_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, dz_only);
        add_row(OP_INV, 2*QONE, QONE, QONE, 3*QONE, 0, 0, 0, 0, 0, 0, zr);
        add_row(OP_INV, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, zr);
        add_row(OP_AINVB, QMAX, QMAX, QMAX, QMAX, 0, 0, 0, 0, 0, 1, dz_only);
        add_row(OP_AINVB, QONE, 2*QONE, 3*QONE, 4*QONE, 2*QONE, 0, 0, 2*QONE, 0, 0, zr);
        add_row(OP_AINVB, QMAX, QMIN, QMAX, QMIN, 1, 0, 0, 1, 0, 0, zr);
        add_row(OP_UNDEF_LO, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0, 1, zr);
        add_row(OP_UNDEF_HI, QMIN, 1, 2, 3, 0, 0, 0, 0, 0, 1, zr);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_beat(rows[i].op, rows[i].a, rows[i].b, rows[i].s, rows[i].fixed, rows[i].exp);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            for (int i = 0; i < 4; i++)
            begin
                a[i] = rand_q();
                b[i] = rand_q();
            end
            s = rand_q();
            if ((op == OP_INV || op == OP_AINVB || op == OP_DET) && $urandom_range(0, 5) == 0)
            begin
                a[3] = a[1];
                a[2] = a[0];
                b[3] = b[1];
                b[2] = b[0];
            end
            send_beat(op, a, b, s, 1'b0, zr);
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (60) @(posedge clk);
        $display("Sent %0d beats, %0d results checked, %0d mismatches.",
                 n_sent, n_checked, fails);
        $display("Beats per op: add %0d sub %0d mul %0d smul %0d sdiv %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        $display("  mv %0d tr %0d det %0d inv %0d ainvb %0d",
                 op_seen[5], op_seen[6], op_seen[7], op_seen[8], op_seen[9]);
        if (fails == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        int g;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(negedge clk)
    begin
        mres_t exp, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.r = m_tdata[127:0];
            got.sc = m_tdata[159:128];
            got.sat = m_tuser[0];
            got.dz = m_tuser[1];
            if (pending_results.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected result beat %h %b", $time, m_tdata, m_tuser);
            end
            else
            begin
                exp = pending_results.pop_front();
                n_checked++;
                for (int i = 0; i < 4; i++)
                    if (got.r[i] !== exp.r[i])
                    begin
                        fails++;
                        $display("%0t: r[%0d] expected %h actual %h", $time, i, exp.r[i], got.r[i]);
                    end
                if (got.sc !== exp.sc)
                begin
                    fails++;
                    $display("%0t: scalar_out expected %h actual %h", $time, exp.sc, got.sc);
                end
                if (got.sat !== exp.sat)
                begin
                    fails++;
                    $display("%0t: saturated expected %b actual %b", $time, exp.sat, got.sat);
                end
                if (got.dz !== exp.dz)
                begin
                    fails++;
                    $display("%0t: divide_by_zero expected %b actual %b", $time, exp.dz, got.dz);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

endmodule
